// ===== rtl/swfi_pkg.sv =====
// Shared types, constants and helpers of the scheduled write fault injector.
// No dependencies; every other file of the block but swfi_ram imports this package.
package swfi_pkg;

   // Payload widths.
   localparam int WORD_W  = 64;
   localparam int CNT_W   = 16;
   localparam int IDX_W   = 48;
   localparam int REG_W   = 32;
   localparam int EAT_W   = 8;
   localparam int PROB_W  = 10;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 3;

   // Ring geometry default.
   localparam int RING_DEPTH_DEF = 1536;

   // Queue between the scheduler and the ring back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Hit evaluation limits and the draw remainder by reciprocal multiply.
   localparam int MAX_EVALS = 3;
   localparam int EVAL_W    = 2;
   localparam int DRAW_W    = 24;
   localparam int QUOT_W    = 15;
   localparam int PROD_W    = 49;
   localparam int MOD_SHIFT = 34;
   localparam logic [24:0] MOD_RECIP = 25'd17179870;
   localparam int PROB_SCALE = 1000;

   // Byte sum of one word.
   localparam int BSUM_W = 11;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUPER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EAT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PROB   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SEED   = 3'd6;

   // Operating modes; the unused code behaves as repair mode.
   localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STALE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPAIR = 2'd2;

   // Register reset values.
   localparam logic [MODE_W-1:0] MODE_DEF   = MODE_PASS;
   localparam logic [REG_W-1:0]  SUPER_DEF  = 32'd6144;
   localparam logic [REG_W-1:0]  OFFSET_DEF = 32'd1536;
   localparam logic [REG_W-1:0]  START_DEF  = 32'd0;
   localparam logic [EAT_W-1:0]  EAT_DEF    = 8'd1;
   localparam logic [PROB_W-1:0] PROB_DEF   = 10'd40;
   localparam logic [REG_W-1:0]  SEED_DEF   = 32'd1;

   // One classified item on its way to the ring back end.
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              swallowed;
      logic              stale;
   } swfi_entry_type;

   // One delivered result item.
   typedef struct packed {
      logic [WORD_W-1:0] out_word;
      logic              out_last;
      logic              swallowed;
      logic              stale;
      logic [CNT_W-1:0]  frame_checksum;
      logic [CNT_W-1:0]  frame_words;
      logic [CNT_W-1:0]  frame_swallowed;
      logic [CNT_W-1:0]  frame_stale;
      logic [CNT_W-1:0]  frame_repaired;
   } swfi_result_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } swfi_qstat_type;

   // Saturating increment of a frame counter.
   function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
      sat_inc16 = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

// ===== rtl/swfi_if.sv =====
// Channel interfaces of the scheduled write fault injector: input items,
// result items and configuration writes. Depends on swfi_pkg.

interface swfi_req_if;
   import swfi_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] in_word;
   logic              in_last;
   modport source (output valid, in_word, in_last, input ready);
   modport sink   (input valid, in_word, in_last, output ready);
endinterface

interface swfi_rsp_if;
   import swfi_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;
   logic              out_last;
   logic              swallowed;
   logic              stale;
   logic [CNT_W-1:0]  frame_checksum;
   logic [CNT_W-1:0]  frame_words;
   logic [CNT_W-1:0]  frame_swallowed;
   logic [CNT_W-1:0]  frame_stale;
   logic [CNT_W-1:0]  frame_repaired;
   modport source (output valid, out_word, out_last, swallowed, stale, frame_checksum,
                   frame_words, frame_swallowed, frame_stale, frame_repaired,
                   input ready);
   modport sink   (input valid, out_word, out_last, swallowed, stale, frame_checksum,
                   frame_words, frame_swallowed, frame_stale, frame_repaired,
                   output ready);
endinterface

interface swfi_csr_if;
   import swfi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/scheduled_write_fault_injector_unit.sv =====
// Top level of the scheduled write fault injector: front end, queue, back end.
// Depends on swfi_pkg, swfi_if, swfi_front, swfi_queue, swfi_back.

// Each accepted 64-bit word goes through a front end that runs the hit schedule
// and a back end that works on the RING_DEPTH-entry ring store; a two-entry
// queue lets each side stall on its own, and the result register lets a new
// word in while a result waits. The front end takes each word through its idle,
// evaluation and decide states, staying in evaluation while hits fall due on
// the word (0 to 3); there it draws one xorshift number per cycle and judges
// it in the next. It takes no new word until the last is pushed. The back end
// takes each word through its idle and calc states and the ring's registered
// read port. After reset the ring is cleared one entry per cycle (1536 entries
// by default); no word is accepted then, but configuration writes always are.
module scheduled_write_fault_injector_unit #(
   parameter int RING_DEPTH = swfi_pkg::RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   swfi_req_if.sink   req_ch,
   swfi_rsp_if.source rsp_ch,
   swfi_csr_if.sink   csr_ch
);
   import swfi_pkg::*;

   logic           clearing;
   logic           q_push, q_pop;
   swfi_entry_type q_entry, q_head;
   swfi_qstat_type q_stat;

   // Scheduler and swallow decision.
   swfi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .csr_ch   (csr_ch),
      .clearing (clearing),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // Queue of classified items.
   swfi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // Ring store and frame statistics.
   swfi_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_ch   (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   // No word enters while the ring is being cleared.
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_ch.ready)
      else $error("input ready while ring clearing");

   // No result appears before the ring clearing pass is done.
   a_no_result_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !rsp_ch.valid)
      else $error("result valid while ring clearing");

   // The front end never pushes into a full queue.
   a_no_push_when_full: assert property (
      @(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("queue push while full");

   // The back end never pops an empty queue.
   a_no_pop_when_empty: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> !q_stat.empty)
      else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/swfi_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module swfi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port share one address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/swfi_front.sv =====
// Front end: configuration registers, hit schedule, xorshift draws and the
// swallow decision for each accepted item. Depends on swfi_pkg, swfi_if.
module swfi_front (
   input  logic                     clock,
   input  logic                     reset,
   swfi_req_if.sink                 req_ch,
   swfi_csr_if.sink                 csr_ch,
   input  logic                     clearing,
   input  swfi_pkg::swfi_qstat_type q_stat,
   output logic                     q_push,
   output swfi_pkg::swfi_entry_type q_entry
);
   import swfi_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_EVAL   = 3'b010,
      F_DECIDE = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;
   logic [EVAL_W-1:0] evals_ff, evals_in;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [REG_W-1:0]  super_ff, super_in;
   logic [REG_W-1:0]  offset_ff, offset_in;
   logic [EAT_W-1:0]  eat_ff, eat_in;
   logic [PROB_W-1:0] prob_ff, prob_in;

   logic [IDX_W-1:0]  pair_start_ff, pair_start_in;
   logic [IDX_W-1:0]  next_hit_ff, next_hit_in;
   logic              second_leg_ff, second_leg_in;
   logic [IDX_W-1:0]  word_index_ff, word_index_in;
   logic [CNT_W-1:0]  pending_ff, pending_in;
   logic [REG_W-1:0]  prng_ff, prng_in;

   logic              chk_valid_ff, chk_valid_in;
   logic [DRAW_W-1:0] chk_v_ff, chk_v_in;
   logic [QUOT_W-1:0] chk_q_ff, chk_q_in;

   logic [REG_W-1:0]  x1, x2, x_new;
   logic [PROD_W-1:0] prod;
   logic [DRAW_W-1:0] remainder;
   logic              admit;
   logic [CNT_W:0]    pend_sum;
   logic [CNT_W-1:0]  pend_sat, pend_cur;
   logic              inject, due, swallow;
   logic [IDX_W-1:0]  pair_next;

   // Next xorshift state and the quotient of its upper 24 bits by 1000 through a reciprocal.
   always_comb begin
      x1    = prng_ff ^ (prng_ff << 13);
      x2    = x1 ^ (x1 >> 17);
      x_new = x2 ^ (x2 << 5);
      prod  = PROD_W'(x_new[31:8]) * PROD_W'(MOD_RECIP);
   end

   // Second half of a draw: remainder, admission and the pending swallows.
   always_comb begin
      remainder = chk_v_ff - DRAW_W'(DRAW_W'(chk_q_ff) * DRAW_W'(PROB_SCALE));
      admit     = remainder < DRAW_W'(prob_ff);
      pend_sum  = (CNT_W+1)'(pending_ff) + (CNT_W+1)'(eat_ff);
      pend_sat  = pend_sum[CNT_W] ? {CNT_W{1'b1}} : pend_sum[CNT_W-1:0];
      pend_cur  = (chk_valid_ff && admit) ? pend_sat : pending_ff;
   end

   // Schedule tests.
   assign inject    = (mode_ff != MODE_PASS);
   assign due       = inject && (evals_ff != EVAL_W'(MAX_EVALS)) &&
                      (word_index_ff >= next_hit_ff);
   assign swallow   = inject && (pend_cur != '0);
   assign pair_next = pair_start_ff + IDX_W'(super_ff);

   assign req_ch.ready = (state_ff == F_IDLE) && !clearing;
   assign csr_ch.ready = 1'b1;

   // Item sent to the queue.
   always_comb begin
      q_entry.word      = word_ff;
      q_entry.last      = last_ff;
      q_entry.swallowed = swallow;
      q_entry.stale     = swallow && (mode_ff == MODE_STALE);
   end

   // Sequencer and configuration writes.
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      evals_in      = evals_ff;
      mode_in       = mode_ff;
      super_in      = super_ff;
      offset_in     = offset_ff;
      eat_in        = eat_ff;
      prob_in       = prob_ff;
      pair_start_in = pair_start_ff;
      next_hit_in   = next_hit_ff;
      second_leg_in = second_leg_ff;
      word_index_in = word_index_ff;
      pending_in    = pend_cur;
      prng_in       = prng_ff;
      chk_valid_in  = 1'b0;
      chk_v_in      = chk_v_ff;
      chk_q_in      = chk_q_ff;
      q_push        = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               word_in  = req_ch.in_word;
               last_in  = req_ch.in_last;
               evals_in = '0;
               state_in = F_EVAL;
            end
         end
         F_EVAL: begin
            // One due hit per cycle: draw now, judge the draw next cycle.
            if (due) begin
               prng_in      = x_new;
               chk_valid_in = 1'b1;
               chk_v_in     = x_new[31:8];
               chk_q_in     = prod[MOD_SHIFT +: QUOT_W];
               evals_in     = evals_ff + 1'b1;
               if (!second_leg_ff) begin
                  second_leg_in = 1'b1;
                  next_hit_in   = pair_start_ff + IDX_W'(offset_ff);
               end else begin
                  second_leg_in = 1'b0;
                  pair_start_in = pair_next;
                  next_hit_in   = pair_next;
               end
            end else begin
               state_in = F_DECIDE;
            end
         end
         F_DECIDE: begin
            if (!q_stat.full) begin
               q_push        = 1'b1;
               pending_in    = pend_cur - CNT_W'(swallow);
               word_index_in = word_index_ff + 1'b1;
               state_in      = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_MODE:   mode_in   = csr_ch.data[MODE_W-1:0];
            REG_SUPER:  super_in  = csr_ch.data;
            REG_OFFSET: offset_in = csr_ch.data;
            REG_START: begin
               pair_start_in = IDX_W'(csr_ch.data);
               next_hit_in   = IDX_W'(csr_ch.data);
               second_leg_in = 1'b0;
            end
            REG_EAT:    eat_in    = csr_ch.data[EAT_W-1:0];
            REG_PROB:   prob_in   = csr_ch.data[PROB_W-1:0];
            REG_SEED:   prng_in   = (csr_ch.data == '0) ? REG_W'(1) : csr_ch.data;
            default: ;
         endcase
      end
   end

   // Control and schedule registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         evals_ff      <= '0;
         mode_ff       <= MODE_DEF;
         super_ff      <= SUPER_DEF;
         offset_ff     <= OFFSET_DEF;
         eat_ff        <= EAT_DEF;
         prob_ff       <= PROB_DEF;
         pair_start_ff <= IDX_W'(START_DEF);
         next_hit_ff   <= IDX_W'(START_DEF);
         second_leg_ff <= 1'b0;
         word_index_ff <= '0;
         pending_ff    <= '0;
         prng_ff       <= SEED_DEF;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         evals_ff      <= evals_in;
         mode_ff       <= mode_in;
         super_ff      <= super_in;
         offset_ff     <= offset_in;
         eat_ff        <= eat_in;
         prob_ff       <= prob_in;
         pair_start_ff <= pair_start_in;
         next_hit_ff   <= next_hit_in;
         second_leg_ff <= second_leg_in;
         word_index_ff <= word_index_in;
         pending_ff    <= pending_in;
         prng_ff       <= prng_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      last_ff  <= last_in;
      chk_v_ff <= chk_v_in;
      chk_q_ff <= chk_q_in;
   end

endmodule

// ===== rtl/swfi_queue.sv =====
// Short queue of classified items between the front end and the ring back end.
// Depends on swfi_pkg.
module swfi_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  swfi_pkg::swfi_entry_type push_entry,
   input  logic                     pop,
   output swfi_pkg::swfi_entry_type head,
   output swfi_pkg::swfi_qstat_type stat
);
   import swfi_pkg::*;

   swfi_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = slot_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/swfi_back.sv =====
// Back end: ring store clearing, ring write or stale read, frame checksum and
// counters, and the result register. Depends on swfi_pkg, swfi_if, swfi_ram.
module swfi_back #(
   parameter int RING_DEPTH = swfi_pkg::RING_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swfi_pkg::swfi_qstat_type q_stat,
   input  swfi_pkg::swfi_entry_type q_head,
   output logic                     q_pop,
   output logic                     clearing,
   swfi_rsp_if.source               rsp_ch
);
   import swfi_pkg::*;

   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(RING_DEPTH - 1);

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_CALC  = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   swfi_entry_type    cur_ff, cur_in;
   logic              out_valid_ff, out_valid_in;
   swfi_result_type   out_ff, out_in;
   logic [CNT_W-1:0]  csum_ff, csum_in;
   logic [CNT_W-1:0]  words_ff, words_in;
   logic [CNT_W-1:0]  swal_ff, swal_in;
   logic [CNT_W-1:0]  stale_ff, stale_in;
   logic [CNT_W-1:0]  rep_ff, rep_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic [WORD_W-1:0] delivered;
   logic [BSUM_W-1:0] bsum;
   logic [CNT_W-1:0]  csum_new, words_new, swal_new, stale_new, rep_new;
   logic              out_free;

   swfi_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign clearing = (state_ff == B_CLEAR);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Delivered word, its byte sum and the running frame statistics.
   always_comb begin
      delivered = cur_ff.stale ? ram_rdata : cur_ff.word;
      bsum      = '0;
      for (int i = 0; i < 8; i++) begin
         bsum = bsum + BSUM_W'(delivered[8*i +: 8]);
      end
      csum_new  = csum_ff + CNT_W'(bsum);
      words_new = sat_inc16(words_ff);
      swal_new  = cur_ff.swallowed ? sat_inc16(swal_ff) : swal_ff;
      stale_new = cur_ff.stale ? sat_inc16(stale_ff) : stale_ff;
      rep_new   = (cur_ff.swallowed && !cur_ff.stale) ? sat_inc16(rep_ff) : rep_ff;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      csum_in      = csum_ff;
      words_in     = words_ff;
      swal_in      = swal_ff;
      stale_in     = stale_ff;
      rep_in       = rep_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = wp_ff;
      ram_wdata    = q_head.word;
      q_pop        = 1'b0;

      case (state_ff)
         B_CLEAR: begin
            // Zero one ring entry per cycle after reset.
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_LAST) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            // Take the next item: stale items read the ring, others write it.
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               ram_re   = q_head.stale;
               ram_we   = !q_head.stale;
               wp_in    = (wp_ff == ADDR_LAST) ? '0 : wp_ff + 1'b1;
               state_in = B_CALC;
            end
         end
         B_CALC: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.out_word        = delivered;
               out_in.out_last        = cur_ff.last;
               out_in.swallowed       = cur_ff.swallowed;
               out_in.stale           = cur_ff.stale;
               out_in.frame_checksum  = csum_new;
               out_in.frame_words     = words_new;
               out_in.frame_swallowed = swal_new;
               out_in.frame_stale     = stale_new;
               out_in.frame_repaired  = rep_new;
               csum_in  = cur_ff.last ? '0 : csum_new;
               words_in = cur_ff.last ? '0 : words_new;
               swal_in  = cur_ff.last ? '0 : swal_new;
               stale_in = cur_ff.last ? '0 : stale_new;
               rep_in   = cur_ff.last ? '0 : rep_new;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         out_valid_ff <= 1'b0;
         csum_ff      <= '0;
         words_ff     <= '0;
         swal_ff      <= '0;
         stale_ff     <= '0;
         rep_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         out_valid_ff <= out_valid_in;
         csum_ff      <= csum_in;
         words_ff     <= words_in;
         swal_ff      <= swal_in;
         stale_ff     <= stale_in;
         rep_ff       <= rep_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   // Result channel.
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.out_word        = out_ff.out_word;
   assign rsp_ch.out_last        = out_ff.out_last;
   assign rsp_ch.swallowed       = out_ff.swallowed;
   assign rsp_ch.stale           = out_ff.stale;
   assign rsp_ch.frame_checksum  = out_ff.frame_checksum;
   assign rsp_ch.frame_words     = out_ff.frame_words;
   assign rsp_ch.frame_swallowed = out_ff.frame_swallowed;
   assign rsp_ch.frame_stale     = out_ff.frame_stale;
   assign rsp_ch.frame_repaired  = out_ff.frame_repaired;

endmodule
